// ----- src/length_prefixed_frame_validator_macros.svh -----
// Assertion macros shared by the frame validator.
`ifndef LENGTH_PREFIXED_FRAME_VALIDATOR_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_VALIDATOR_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define LPFV_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define LPFV_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

// ----- src/lpfv_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame validator package
// Result, config and queue types, status codes, field ids, register indexes.
// ---------------------------------------------------------------------------
package lpfv_pkg;
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNC     = 2'd1;
    localparam logic [1:0] ST_VERSION   = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    localparam logic [1:0] FID_URL  = 2'd0;
    localparam logic [1:0] FID_HOST = 2'd1;
    localparam logic [1:0] FID_CTX  = 2'd2;
    localparam logic [1:0] FID_SIG  = 2'd3;

    localparam logic [2:0] REG_VERSION  = 3'd0;
    localparam logic [2:0] REG_MAX_URL  = 3'd1;
    localparam logic [2:0] REG_MAX_HOST = 3'd2;
    localparam logic [2:0] REG_MAX_CTX  = 3'd3;
    localparam logic [2:0] REG_SIG      = 3'd4;
    localparam logic [2:0] REG_MAX_CONT = 3'd5;
    localparam logic [2:0] REG_PLAIN    = 3'd6;
    localparam logic [2:0] REG_SECURE   = 3'd7;

    typedef struct packed {
        logic        is_verdict;
        logic [1:0]  field_id;
        logic [7:0]  field_byte;
        logic [1:0]  status;
        logic [7:0]  rx_version;
        logic [7:0]  content_code;
        logic [31:0] capability_bits;
        logic        is_secure;
        logic        agent_flag;
    } t_result;

    typedef struct packed {
        logic [7:0]  expected_version;
        logic [15:0] max_url;
        logic [15:0] max_host;
        logic [19:0] max_ctx;
        logic [7:0]  sig_bytes;
        logic [7:0]  max_content;
        logic [7:0]  plain_code;
        logic [7:0]  secure_code;
    } t_cfg;

    // Front-to-back queue entry: up to two results caused by one item.
    typedef struct packed {
        logic    has_first;
        t_result first;
        logic    has_second;
        t_result second;
    } t_work;
endpackage

// ----- src/length_prefixed_frame_validator.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Length-prefixed frame validator
// Parses one framed buffer a byte at a time and emits field bytes and a verdict.
// ---------------------------------------------------------------------------
// The input channel takes one buffer byte per item with a last-byte flag.
// The output channel gives tagged string bytes as they arrive and one verdict
// per buffer: ok, truncated, version mismatch or malformed.
// Configuration is to be written by the user through the plain write port
// only while the block is idle; the block itself does not enforce this.
// A byte is taken every cycle while the output keeps up. Its results pass
// through the parser register and then the two-entry queue. A byte causing
// both a field byte and a verdict yields two output items, so the rate is one
// item per cycle while the receiver is ready, bar that single byte per buffer.
// Reset returns the parser to the length header and the registers to their
// defaults. When the receiver stalls, the queue fills and then input ready
// drops; nothing is lost.
// ---------------------------------------------------------------------------
`include "length_prefixed_frame_validator_macros.svh"
module length_prefixed_frame_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_buffer_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_verdict,
    output logic [1:0]  o_field_id,
    output logic [7:0]  o_field_byte,
    output logic [1:0]  o_status,
    output logic [7:0]  o_rx_version,
    output logic [7:0]  o_content_code,
    output logic [31:0] o_capability_bits,
    output logic        o_is_secure,
    output logic        o_agent_flag,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    lpfv_pkg::t_cfg    r_cfg;
    lpfv_pkg::t_work   work;
    lpfv_pkg::t_result res;
    logic              work_valid, work_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_version <= 8'd5;
            r_cfg.max_url <= 16'd16384;
            r_cfg.max_host <= 16'd512;
            r_cfg.max_ctx <= 20'd4096;
            r_cfg.sig_bytes <= 8'd64;
            r_cfg.max_content <= 8'd15;
            r_cfg.plain_code <= 8'd0;
            r_cfg.secure_code <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lpfv_pkg::REG_VERSION:  r_cfg.expected_version <= i_cfg_data[7:0];
                lpfv_pkg::REG_MAX_URL:  r_cfg.max_url <= i_cfg_data[15:0];
                lpfv_pkg::REG_MAX_HOST: r_cfg.max_host <= i_cfg_data[15:0];
                lpfv_pkg::REG_MAX_CTX:  r_cfg.max_ctx <= i_cfg_data;
                lpfv_pkg::REG_SIG:      r_cfg.sig_bytes <= i_cfg_data[7:0];
                lpfv_pkg::REG_MAX_CONT: r_cfg.max_content <= i_cfg_data[7:0];
                lpfv_pkg::REG_PLAIN:    r_cfg.plain_code <= i_cfg_data[7:0];
                lpfv_pkg::REG_SECURE:   r_cfg.secure_code <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    lpfv_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_valid(i_valid),
        .i_data_byte(i_data_byte), .i_buffer_end(i_buffer_end), .o_ready(o_ready),
        .o_work_valid(work_valid), .o_work(work), .i_work_ready(work_ready)
    );

    lpfv_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_work_valid(work_valid), .i_work(work),
        .o_work_ready(work_ready), .o_valid(o_valid), .o_result(res), .i_ready(i_ready)
    );

    assign o_is_verdict      = res.is_verdict;
    assign o_field_id        = res.field_id;
    assign o_field_byte      = res.field_byte;
    assign o_status          = res.status;
    assign o_rx_version      = res.rx_version;
    assign o_content_code    = res.content_code;
    assign o_capability_bits = res.capability_bits;
    assign o_is_secure       = res.is_secure;
    assign o_agent_flag      = res.agent_flag;

    `LPFV_ASSERT_IMP(a_verdict_no_field, i_clk, i_rst_n, o_valid && o_is_verdict,
        o_field_id == 2'd0 && o_field_byte == 8'd0, "verdict carries field data")
    `LPFV_ASSERT_IMP(a_trunc_clean, i_clk, i_rst_n,
        o_valid && o_is_verdict && o_status == lpfv_pkg::ST_TRUNC,
        o_rx_version == 8'd0 && o_capability_bits == 32'd0, "truncated verdict not clean")
    `LPFV_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid, "output valid dropped while stalled")
endmodule

// ----- src/lpfv_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame validator front end
// Parses one byte per cycle unless stalled; produces the results each byte causes.
// ---------------------------------------------------------------------------
module lpfv_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lpfv_pkg::t_cfg   i_cfg,
    input  logic             i_valid,
    input  logic [7:0]       i_data_byte,
    input  logic             i_buffer_end,
    output logic             o_ready,
    output logic             o_work_valid,
    output lpfv_pkg::t_work  o_work,
    input  logic             i_work_ready
);
    typedef enum logic [3:0] {
        PH_HDR, PH_VER, PH_URL_LEN, PH_URL, PH_HOST_LEN, PH_HOST, PH_CONTENT,
        PH_MASK, PH_SCHEME, PH_AGENT, PH_CTX_LEN, PH_CTX, PH_SIG_LEN, PH_SIG,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_frame_len, n_frame_len;
    logic [32:0] r_seen, n_seen;
    logic [31:0] r_field_len, n_field_len;
    logic [31:0] r_remain, n_remain;
    logic [7:0]  r_version, n_version;
    logic [1:0]  r_error, n_error;
    logic [7:0]  r_content, n_content;
    logic [1:0]  r_shift, n_shift;
    logic        r_secure, n_secure;
    logic        r_agent, n_agent;
    logic        r_ctx, n_ctx;
    logic        r_done, n_done;
    logic [31:0] r_cap, n_cap;

    lpfv_pkg::t_work n_work;
    logic            accept;
    logic [31:0]     word;
    logic [31:0]     limit;
    logic [1:0]      st;
    logic            verdict;
    logic            field_out;
    logic [1:0]      fid;
    logic [31:0]     rem_dec;

    assign o_ready = !o_work_valid || i_work_ready;
    assign accept  = i_valid && o_ready;
    assign word    = {r_field_len[23:0], i_data_byte};
    assign rem_dec = r_remain - 32'd1;

    always_comb begin
        n_phase = r_phase; n_frame_len = r_frame_len; n_seen = r_seen;
        n_field_len = r_field_len; n_remain = r_remain; n_version = r_version;
        n_error = r_error; n_content = r_content; n_shift = r_shift;
        n_secure = r_secure; n_agent = r_agent; n_ctx = r_ctx; n_done = r_done;
        n_cap = r_cap;
        field_out = 1'b0; fid = lpfv_pkg::FID_URL; limit = '0; verdict = 1'b0;
        st = lpfv_pkg::ST_OK; n_work = '0;
        if (!r_done) begin
            n_seen = r_seen + 33'd1;
            if (r_phase == PH_HDR) begin
                n_frame_len = {r_frame_len[23:0], i_data_byte};
                if (r_seen >= 33'd3) n_phase = PH_VER;
            end else if (r_phase == PH_VER) begin
                n_version = i_data_byte;
                if (i_data_byte != i_cfg.expected_version) begin
                    n_error = lpfv_pkg::ST_VERSION; n_phase = PH_DONE;
                end else begin
                    n_phase = PH_URL_LEN; n_shift = '0; n_field_len = '0;
                end
            end else if (r_error == lpfv_pkg::ST_OK) begin
                unique case (r_phase)
                    PH_URL_LEN, PH_HOST_LEN, PH_CTX_LEN: begin
                        n_field_len = word;
                        n_shift = r_shift + 2'd1;
                        if (r_shift == 2'd3) begin
                            n_field_len = '0;
                            if (r_phase == PH_URL_LEN) limit = {16'd0, i_cfg.max_url};
                            else if (r_phase == PH_HOST_LEN) limit = {16'd0, i_cfg.max_host};
                            else limit = {12'd0, i_cfg.max_ctx};
                            if (word > limit) begin
                                n_error = lpfv_pkg::ST_MALFORMED; n_phase = PH_DONE;
                            end else begin
                                if (r_phase == PH_CTX_LEN) n_ctx = word != '0;
                                if (word == '0) begin
                                    n_phase = (r_phase == PH_URL_LEN) ? PH_HOST_LEN
                                            : (r_phase == PH_HOST_LEN) ? PH_CONTENT
                                            : PH_SIG_LEN;
                                end else begin
                                    n_remain = word;
                                    n_phase = (r_phase == PH_URL_LEN) ? PH_URL
                                            : (r_phase == PH_HOST_LEN) ? PH_HOST : PH_CTX;
                                end
                            end
                        end
                    end
                    PH_URL, PH_HOST, PH_CTX, PH_SIG: begin
                        field_out = 1'b1;
                        fid = (r_phase == PH_URL) ? lpfv_pkg::FID_URL
                            : (r_phase == PH_HOST) ? lpfv_pkg::FID_HOST
                            : (r_phase == PH_CTX) ? lpfv_pkg::FID_CTX : lpfv_pkg::FID_SIG;
                        n_remain = rem_dec;
                        if (r_remain == 32'd1) begin
                            if (r_phase == PH_SIG) begin
                                if (!r_ctx) n_error = lpfv_pkg::ST_MALFORMED;
                                n_phase = PH_DONE;
                            end else begin
                                n_shift = '0; n_field_len = '0;
                                n_phase = (r_phase == PH_URL) ? PH_HOST_LEN
                                        : (r_phase == PH_HOST) ? PH_CONTENT : PH_SIG_LEN;
                            end
                        end
                    end
                    PH_CONTENT: begin
                        if (i_data_byte > i_cfg.max_content) begin
                            n_error = lpfv_pkg::ST_MALFORMED; n_phase = PH_DONE;
                        end else begin
                            n_content = i_data_byte; n_phase = PH_MASK;
                            n_shift = '0; n_cap = '0;
                        end
                    end
                    PH_MASK: begin
                        n_cap = {r_cap[23:0], i_data_byte};
                        n_shift = r_shift + 2'd1;
                        if (r_shift == 2'd3) n_phase = PH_SCHEME;
                    end
                    PH_SCHEME: begin
                        if (i_data_byte == i_cfg.plain_code) begin
                            n_secure = 1'b0; n_phase = PH_AGENT;
                        end else if (i_data_byte == i_cfg.secure_code) begin
                            n_secure = 1'b1; n_phase = PH_AGENT;
                        end else begin
                            n_error = lpfv_pkg::ST_MALFORMED; n_phase = PH_DONE;
                        end
                    end
                    PH_AGENT: begin
                        n_agent = i_data_byte != 8'd0; n_phase = PH_CTX_LEN;
                        n_shift = '0; n_field_len = '0;
                    end
                    PH_SIG_LEN: begin
                        if (i_data_byte != 8'd0 && i_data_byte != i_cfg.sig_bytes) begin
                            n_error = lpfv_pkg::ST_MALFORMED; n_phase = PH_DONE;
                        end else if (i_data_byte == 8'd0) begin
                            if (r_ctx) n_error = lpfv_pkg::ST_MALFORMED;
                            n_phase = PH_DONE;
                        end else begin
                            n_remain = {24'd0, i_data_byte}; n_phase = PH_SIG;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // Frame end reached when seen >= max(5, 4 + L); L is final after byte 4.
            if (n_seen >= 33'd5 && n_seen >= ({1'b0, r_frame_len} + 33'd4))
                verdict = 1'b1;
            if (verdict) begin
                st = (n_error != lpfv_pkg::ST_OK) ? n_error
                   : (n_phase != PH_DONE) ? lpfv_pkg::ST_MALFORMED : lpfv_pkg::ST_OK;
            end else if (i_buffer_end) begin
                verdict = 1'b1; st = lpfv_pkg::ST_TRUNC;
            end
            n_work.has_first = field_out || verdict;
            n_work.has_second = field_out && verdict;
            if (field_out) begin
                n_work.first.field_id = fid;
                n_work.first.field_byte = i_data_byte;
            end
            if (verdict) begin
                n_work.second.is_verdict = 1'b1;
                n_work.second.status = st;
                if (st != lpfv_pkg::ST_TRUNC) n_work.second.rx_version = n_version;
                if (st == lpfv_pkg::ST_OK) begin
                    n_work.second.content_code = n_content;
                    n_work.second.capability_bits = n_cap;
                    n_work.second.is_secure = n_secure;
                    n_work.second.agent_flag = n_agent;
                end
                if (!field_out) n_work.first = n_work.second;
                n_done = 1'b1;
            end
        end
        if ((r_done || verdict) && i_buffer_end) begin
            n_phase = PH_HDR; n_frame_len = '0; n_seen = '0; n_field_len = '0;
            n_remain = '0; n_version = '0; n_error = '0; n_content = '0; n_shift = '0;
            n_secure = 1'b0; n_agent = 1'b0; n_ctx = 1'b0; n_done = 1'b0; n_cap = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR; r_frame_len <= '0; r_seen <= '0; r_field_len <= '0;
            r_remain <= '0; r_version <= '0; r_error <= '0; r_content <= '0;
            r_shift <= '0; r_secure <= 1'b0; r_agent <= 1'b0; r_ctx <= 1'b0;
            r_done <= 1'b0; r_cap <= '0; o_work_valid <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase; r_frame_len <= n_frame_len; r_seen <= n_seen;
            r_field_len <= n_field_len; r_remain <= n_remain; r_version <= n_version;
            r_error <= n_error; r_content <= n_content; r_shift <= n_shift;
            r_secure <= n_secure; r_agent <= n_agent; r_ctx <= n_ctx;
            r_done <= n_done; r_cap <= n_cap;
            o_work_valid <= n_work.has_first;
        end else if (i_work_ready) begin
            o_work_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) o_work <= n_work;
    end
endmodule

// ----- src/lpfv_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame validator back end
// Two-entry queue of work items, unrolled into one result per output item.
// ---------------------------------------------------------------------------
module lpfv_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_work_valid,
    input  lpfv_pkg::t_work   i_work,
    output logic              o_work_ready,
    output logic              o_valid,
    output lpfv_pkg::t_result o_result,
    input  logic              i_ready
);
    lpfv_pkg::t_work r_mem [2];
    logic            r_wr, r_rd;
    logic [1:0]      r_count;
    logic            r_second;
    logic            push, pop;
    lpfv_pkg::t_work head;

    assign head         = r_mem[r_rd];
    assign o_work_ready = r_count != 2'd2;
    assign push         = i_work_valid && o_work_ready;
    assign o_valid      = r_count != 2'd0;
    assign o_result     = r_second ? head.second : head.first;
    assign pop          = o_valid && i_ready && (r_second || !head.has_second);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0; r_rd <= 1'b0; r_count <= '0; r_second <= 1'b0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (pop) begin
                r_rd <= !r_rd; r_second <= 1'b0;
            end else if (o_valid && i_ready) begin
                r_second <= 1'b1;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_work;
    end
endmodule

// ----- tb/sv/tb_length_prefixed_frame_validator.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame validator testbench
// Streams framed buffers through the validator under random input gaps and
// output stalls, and checks every field byte and verdict against a built-in
// model of the parser that runs over each accepted item.
// ---------------------------------------------------------------------------
module tb_length_prefixed_frame_validator;
    typedef enum logic [3:0] {
        P_HDR, P_VER, P_URL_LEN, P_URL, P_HOST_LEN, P_HOST, P_CONTENT, P_MASK,
        P_SCHEME, P_AGENT, P_CTX_LEN, P_CTX, P_SIG_LEN, P_SIG, P_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_buffer_end;
    logic        o_valid;
    logic        i_ready;
    logic        o_is_verdict;
    logic [1:0]  o_field_id;
    logic [7:0]  o_field_byte;
    logic [1:0]  o_status;
    logic [7:0]  o_rx_version;
    logic [7:0]  o_content_code;
    logic [31:0] o_capability_bits;
    logic        o_is_secure;
    logic        o_agent_flag;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [19:0] i_cfg_data;

    length_prefixed_frame_validator u_top (.*);

    t_item             pending_bytes[$];
    lpfv_pkg::t_result expected_results[$];
    lpfv_pkg::t_cfg    cfg;
    int                errors;
    int                cycles;
    int                in_gap;
    int                out_gap;
    logic              o_ready_seen;
    logic              o_taken;

    t_phase      phase;
    logic [31:0] frame_len;
    logic [32:0] seen;
    logic [31:0] fld_len;
    logic [31:0] fld_left;
    logic [7:0]  ver_seen;
    logic [1:0]  err;
    logic [7:0]  cont_seen;
    logic [31:0] word_cnt;
    logic        sec_seen;
    logic        agt_seen;
    logic        ctx_present;
    logic        done;
    logic [31:0] cap_word;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic lpfv_pkg::t_result blank();
        lpfv_pkg::t_result r;
        r = '0;
        return r;
    endfunction

    task automatic clear_frame();
        phase = P_HDR; frame_len = '0; seen = '0; fld_len = '0; fld_left = '0;
        ver_seen = '0; err = lpfv_pkg::ST_OK; cont_seen = '0; word_cnt = '0;
        sec_seen = 1'b0; agt_seen = 1'b0; ctx_present = 1'b0; done = 1'b0;
        cap_word = '0;
    endtask

    task automatic mark_malformed();
        err = lpfv_pkg::ST_MALFORMED;
        phase = P_DONE;
    endtask

    task automatic close_signature(input logic sig_present);
        if (ctx_present != sig_present) mark_malformed();
        else phase = P_DONE;
    endtask

    task automatic parse_body(input logic [7:0] b);
        lpfv_pkg::t_result r;
        logic [31:0] limit;
        logic [1:0] fid;
        t_phase body;
        t_phase nxt;
        r = blank();
        case (phase)
            P_URL_LEN, P_HOST_LEN, P_CTX_LEN: begin
                fld_len = {fld_len[23:0], b};
                word_cnt++;
                if (word_cnt < 32'd4) return;
                word_cnt = '0;
                if (phase == P_URL_LEN) begin
                    limit = {16'd0, cfg.max_url}; body = P_URL; nxt = P_HOST_LEN;
                end else if (phase == P_HOST_LEN) begin
                    limit = {16'd0, cfg.max_host}; body = P_HOST; nxt = P_CONTENT;
                end else begin
                    limit = {12'd0, cfg.max_ctx}; body = P_CTX; nxt = P_SIG_LEN;
                end
                if (fld_len > limit) begin
                    mark_malformed();
                    return;
                end
                if (phase == P_CTX_LEN) ctx_present = fld_len != 32'd0;
                if (fld_len == 32'd0) phase = nxt;
                else begin
                    fld_left = fld_len;
                    phase = body;
                end
                fld_len = '0;
            end
            P_URL, P_HOST, P_CTX, P_SIG: begin
                fid = (phase == P_URL) ? lpfv_pkg::FID_URL :
                      (phase == P_HOST) ? lpfv_pkg::FID_HOST :
                      (phase == P_CTX) ? lpfv_pkg::FID_CTX : lpfv_pkg::FID_SIG;
                nxt = (phase == P_URL) ? P_HOST_LEN : (phase == P_HOST) ? P_CONTENT :
                      (phase == P_CTX) ? P_SIG_LEN : P_DONE;
                r.field_id = fid;
                r.field_byte = b;
                expected_results.push_back(r);
                if (fld_left > 32'd0) fld_left--;
                if (fld_left == 32'd0) begin
                    if (fid == lpfv_pkg::FID_SIG) close_signature(1'b1);
                    else begin
                        phase = nxt; word_cnt = '0; fld_len = '0;
                    end
                end
            end
            P_CONTENT: begin
                if (b > cfg.max_content) mark_malformed();
                else begin
                    cont_seen = b; phase = P_MASK; word_cnt = '0; cap_word = '0;
                end
            end
            P_MASK: begin
                cap_word = {cap_word[23:0], b};
                word_cnt++;
                if (word_cnt >= 32'd4) begin
                    word_cnt = '0;
                    phase = P_SCHEME;
                end
            end
            P_SCHEME: begin
                if (b == cfg.plain_code) begin
                    sec_seen = 1'b0; phase = P_AGENT;
                end else if (b == cfg.secure_code) begin
                    sec_seen = 1'b1; phase = P_AGENT;
                end else mark_malformed();
            end
            P_AGENT: begin
                agt_seen = b != 8'd0; phase = P_CTX_LEN; word_cnt = '0; fld_len = '0;
            end
            P_SIG_LEN: begin
                if (b != 8'd0 && b != cfg.sig_bytes) mark_malformed();
                else if (b == 8'd0) close_signature(1'b0);
                else begin
                    fld_left = {24'd0, b}; phase = P_SIG;
                end
            end
            default: ;
        endcase
    endtask

    task automatic predict_byte(input t_item it);
        lpfv_pkg::t_result v;
        logic [33:0] frame_end;
        logic verdict;
        if (done) begin
            if (it.last) clear_frame();
            return;
        end
        seen++;
        if (phase == P_HDR) begin
            frame_len = {frame_len[23:0], it.data};
            if (seen >= 33'd4) phase = P_VER;
        end else if (phase == P_VER) begin
            ver_seen = it.data;
            if (it.data != cfg.expected_version) begin
                err = lpfv_pkg::ST_VERSION; phase = P_DONE;
            end else begin
                phase = P_URL_LEN; word_cnt = '0; fld_len = '0;
            end
        end else if (err == lpfv_pkg::ST_OK) begin
            parse_body(it.data);
        end
        frame_end = 34'd4 + {2'd0, frame_len};
        if (frame_end < 34'd5) frame_end = 34'd5;
        v = blank();
        v.is_verdict = 1'b1;
        verdict = 1'b0;
        if (seen >= 33'd5 && {1'b0, seen} >= frame_end) begin
            v.status = (err != lpfv_pkg::ST_OK) ? err :
                       (phase != P_DONE ? lpfv_pkg::ST_MALFORMED : lpfv_pkg::ST_OK);
            v.rx_version = ver_seen;
            if (v.status == lpfv_pkg::ST_OK) begin
                v.content_code = cont_seen; v.capability_bits = cap_word;
                v.is_secure = sec_seen; v.agent_flag = agt_seen;
            end
            verdict = 1'b1;
        end else if (it.last) begin
            v.status = lpfv_pkg::ST_TRUNC;
            verdict = 1'b1;
        end
        if (verdict) begin
            expected_results.push_back(v);
            if (it.last) clear_frame();
            else done = 1'b1;
        end
    endtask

    // Driver: input changes on the falling edge, after the accepting rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready_seen) begin
                predict_byte(pending_bytes.pop_front());
                in_gap = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 14)) : 0;
            end
            if (!i_valid || o_ready_seen) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    i_valid <= 1'b1;
                    i_data_byte <= pending_bytes[0].data;
                    i_buffer_end <= pending_bytes[0].last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (o_taken) begin
                out_gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 14)) : 0;
            end
            if (out_gap > 0) begin
                out_gap--;
                i_ready <= 1'b0;
            end else i_ready <= 1'b1;
        end
    end

    // Monitor: handshakes are sampled at the rising edge.
    always @(posedge i_clk) begin
        lpfv_pkg::t_result got;
        lpfv_pkg::t_result exp;
        o_ready_seen <= i_rst_n && i_valid && o_ready;
        o_taken <= i_rst_n && o_valid && i_ready;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_is_verdict, o_field_id, o_field_byte, o_status, o_rx_version,
                    o_content_code, o_capability_bits, o_is_secure, o_agent_flag};
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $realtime, got);
                errors <= errors + 1;
            end else begin
                exp = expected_results.pop_front();
                if (got.is_verdict !== exp.is_verdict || got.field_id !== exp.field_id ||
                    got.field_byte !== exp.field_byte || got.status !== exp.status ||
                    got.rx_version !== exp.rx_version ||
                    got.content_code !== exp.content_code ||
                    got.capability_bits !== exp.capability_bits ||
                    got.is_secure !== exp.is_secure || got.agent_flag !== exp.agent_flag) begin
                    $display("%0t result mismatch: expected %h, actual %h",
                             $realtime, exp, got);
                    errors <= errors + 1;
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            lpfv_pkg::REG_VERSION:  cfg.expected_version = val[7:0];
            lpfv_pkg::REG_MAX_URL:  cfg.max_url = val[15:0];
            lpfv_pkg::REG_MAX_HOST: cfg.max_host = val[15:0];
            lpfv_pkg::REG_MAX_CTX:  cfg.max_ctx = val;
            lpfv_pkg::REG_SIG:      cfg.sig_bytes = val[7:0];
            lpfv_pkg::REG_MAX_CONT: cfg.max_content = val[7:0];
            lpfv_pkg::REG_PLAIN:    cfg.plain_code = val[7:0];
            lpfv_pkg::REG_SECURE:   cfg.secure_code = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        t_item it;
        it.data = b;
        it.last = last;
        pending_bytes.push_back(it);
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--) push_byte(w[8*k +: 8], 1'b0);
    endtask

    // Builds one buffer. Lengths stay small; mode picks a corruption, mode 0 none.
    task automatic push_frame(input int mode);
        logic [7:0] body[$];
        int url_n;
        int host_n;
        int ctx_n;
        int sig_n;
        int total;
        int cut;
        logic [31:0] w;
        url_n = int'($urandom_range(0, 6));
        host_n = int'($urandom_range(0, 6));
        ctx_n = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 5));
        sig_n = (ctx_n != 0) ? int'(cfg.sig_bytes) : 0;
        if (cfg.sig_bytes > 8'd8 || cfg.sig_bytes == 8'd0) begin
            ctx_n = 0; sig_n = 0;
        end
        body.push_back((mode == 2) ? cfg.expected_version + 8'd1 : cfg.expected_version);
        w = (mode == 1) ? {16'd0, cfg.max_url} + 32'd1 : 32'(url_n);
        for (int k = 3; k >= 0; k--) body.push_back(w[8*k +: 8]);
        if (mode == 1) url_n = 0;
        repeat (url_n) body.push_back(8'($urandom));
        for (int k = 3; k >= 0; k--) body.push_back(8'(host_n >> (8 * k)));
        repeat (host_n) body.push_back(8'($urandom));
        body.push_back((mode == 3 && cfg.max_content != 8'hff) ? cfg.max_content + 8'd1 :
                       8'($urandom_range(0, cfg.max_content)));
        w = $urandom;
        for (int k = 3; k >= 0; k--) body.push_back(w[8*k +: 8]);
        if (mode == 4) body.push_back(8'hff ^ cfg.plain_code ^ cfg.secure_code ^ 8'h5a);
        else body.push_back(($urandom_range(0, 1) != 0) ? cfg.secure_code : cfg.plain_code);
        body.push_back(($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(1, 255)));
        if (mode == 5 && ctx_n == 0 && cfg.sig_bytes != 8'd0 && cfg.sig_bytes <= 8'd8) begin
            sig_n = int'(cfg.sig_bytes);
        end
        for (int k = 3; k >= 0; k--) body.push_back(8'(ctx_n >> (8 * k)));
        repeat (ctx_n) body.push_back(8'($urandom));
        body.push_back(8'(sig_n));
        repeat (sig_n) body.push_back(8'($urandom));
        if (mode == 6) repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
        total = body.size();
        if (mode == 7) total = int'($urandom_range(0, body.size() + 2));
        push_word(32'(total));
        cut = (mode == 8) ? int'($urandom_range(0, body.size() - 1)) : body.size();
        if (mode == 8 && cut == 0) begin
            pending_bytes[$].last = 1'b1;
            return;
        end
        for (int k = 0; k < cut; k++) push_byte(body[k], k == cut - 1 && mode != 9);
        if (mode == 9) begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
            push_byte(8'($urandom), 1'b1);
        end
    endtask

    task automatic drain();
        while (pending_bytes.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_config(input int level);
        write_reg(lpfv_pkg::REG_VERSION, (level == 0) ? 20'd0 : (level == 1) ? 20'd255 :
                  20'($urandom_range(0, 255)));
        write_reg(lpfv_pkg::REG_MAX_URL, (level == 0) ? 20'd0 :
                  (level == 1) ? 20'hffff : 20'd4);
        write_reg(lpfv_pkg::REG_MAX_HOST, (level == 0) ? 20'd0 :
                  (level == 1) ? 20'hffff : 20'd5);
        write_reg(lpfv_pkg::REG_MAX_CTX, (level == 0) ? 20'd0 :
                  (level == 1) ? 20'hfffff : 20'd3);
        write_reg(lpfv_pkg::REG_SIG, (level == 0) ? 20'd0 : (level == 1) ? 20'd255 :
                  20'($urandom_range(1, 8)));
        write_reg(lpfv_pkg::REG_MAX_CONT, (level == 0) ? 20'd0 : (level == 1) ? 20'd255 :
                  20'($urandom_range(1, 254)));
        write_reg(lpfv_pkg::REG_PLAIN, (level == 0) ? 20'd0 : (level == 1) ? 20'd255 :
                  20'($urandom_range(0, 127)));
        write_reg(lpfv_pkg::REG_SECURE, (level == 0) ? 20'd0 : (level == 1) ? 20'd254 :
                  20'($urandom_range(128, 255)));
    endtask

    initial begin
        errors = 0; cycles = 0; in_gap = 0; out_gap = 0;
        o_ready_seen = 1'b0; o_taken = 1'b0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_data_byte = '0; i_buffer_end = 1'b0;
        i_ready = 1'b0; i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        cfg = '{8'd5, 16'd16384, 16'd512, 20'd4096, 8'd64, 8'd15, 8'd0, 8'd1};
        clear_frame();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Defaults: short length, truncation, mismatch, bytes after the verdict.
        push_word(32'd0); push_byte(8'd5, 1'b1);
        push_word(32'd0); push_byte(8'd9, 1'b0); push_byte(8'hff, 1'b0);
        push_byte(8'd0, 1'b1);
        push_byte(8'hff, 1'b0); push_byte(8'hff, 1'b1);
        push_word(32'hffffffff); push_byte(8'd5, 1'b0); push_byte(8'h80, 1'b1);
        push_frame(0);
        drain();
        random_config(2);
        for (int m = 0; m < 10; m++) push_frame(m);
        drain();
        for (int lv = 0; lv < 6; lv++) begin
            random_config(lv < 2 ? lv : 2);
            if (lv == 5) write_reg(lpfv_pkg::REG_SECURE, {12'd0, cfg.plain_code});
            repeat (3) begin
                push_frame(($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 9)) : 0);
            end
            repeat (3) push_byte(8'($urandom), 1'($urandom_range(0, 1)));
            push_byte(8'($urandom), 1'b1);
            drain();
        end
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycles > 400000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end
endmodule
